// ----- rtl/sitoa_pkg.sv -----
// shared constants and helpers for the signed integer to decimal ascii core
package sitoa_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int CHAR_BITS      = 6;

    // ascii codes, truncated to the character field width
    localparam logic [CHAR_BITS-1:0] DIGIT_BASE = 6'd48;
    localparam logic [CHAR_BITS-1:0] MINUS_CODE = 6'd45;

    // log10(2) as a fraction, used to size the decimal digit store
    localparam int LOG10_2_NUM = 30103;
    localparam int LOG10_2_DEN = 100000;

    // decimal digits needed for a magnitude of up to 2^(bits-1)
    function automatic int digits_for(input int bits);
        return ((bits - 1) * LOG10_2_NUM) / LOG10_2_DEN + 1;
    endfunction

endpackage

// ----- rtl/sitoa_front.sv -----
// front stage: takes the input beat, splits it into sign and unsigned magnitude
module sitoa_front #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_job_valid,
    input  logic                  i_job_stall,
    output logic                  o_job_neg,
    output logic [VALUE_BITS-1:0] o_job_mag
);

    logic                  r_valid;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  w_accept;
    logic                  w_neg;

    // hold the upstream beat only while the staged job cannot move on
    assign o_stall  = r_valid && i_job_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_neg    = i_value[VALUE_BITS-1];

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_job_stall) begin
            r_valid <= 1'b0;
        end
    end

    // sign and magnitude, most negative value wraps to 2^(n-1) unsigned
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= w_neg;
            r_mag <= w_neg ? (~i_value + 1'b1) : i_value;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job_neg   = r_neg;
    assign o_job_mag   = r_mag;

endmodule

// ----- rtl/sitoa_queue.sv -----
// two-entry job queue between the front and back stages
module sitoa_queue #(
    parameter int WIDTH = sitoa_pkg::VALUE_BITS_DEF + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_data
);

    logic             r_v0;
    logic             r_v1;
    logic [WIDTH-1:0] r_d0;
    logic [WIDTH-1:0] r_d1;
    logic             n_v0;
    logic             n_v1;
    logic [WIDTH-1:0] n_d0;
    logic [WIDTH-1:0] n_d1;
    logic             w_push;
    logic             w_pop;

    assign o_stall = r_v1;
    assign w_push  = i_valid && !r_v1;
    assign w_pop   = r_v0 && !i_stall;

    // head slot drains first, tail slot moves up on a pop
    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (w_pop) begin
            n_v0 = r_v1;
            n_d0 = r_d1;
            n_v1 = 1'b0;
        end
        if (w_push) begin
            if (!n_v0) begin
                n_v0 = 1'b1;
                n_d0 = i_data;
            end else begin
                n_v1 = 1'b1;
                n_d1 = i_data;
            end
        end
    end

    // slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

    assign o_valid = r_v0;
    assign o_data  = r_d0;

endmodule

// ----- rtl/sitoa_back.sv -----
// back stage: shift-add binary to bcd, then one character per beat
module sitoa_back #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_valid,
    output logic                               o_job_stall,
    input  logic                               i_job_neg,
    input  logic [VALUE_BITS-1:0]              i_job_mag,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sitoa_pkg::CHAR_BITS-1:0]    o_char_code,
    output logic                               o_is_last
);

    localparam int NUM_DIGITS = sitoa_pkg::digits_for(VALUE_BITS);
    localparam int BCD_BITS   = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_FIND,
        S_SIGN,
        S_DIGIT
    } t_state;

    t_state                         r_state;
    logic                           r_neg;
    logic [VALUE_BITS-1:0]          r_shift;
    logic [BCD_BITS-1:0]            r_bcd;
    logic [CNT_W-1:0]               r_cnt;
    logic [IDX_W-1:0]               r_idx;
    logic                           r_out_valid;
    logic [sitoa_pkg::CHAR_BITS-1:0] r_char;
    logic                           r_last;

    logic [BCD_BITS-1:0]            w_bcd_adj;
    logic [IDX_W-1:0]               w_first_nz;
    logic [3:0]                     w_digit;
    logic                           w_slot_free;
    logic                           w_emit;

    assign o_job_stall = (r_state != S_IDLE);
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_emit      = w_slot_free && (r_state == S_SIGN || r_state == S_DIGIT);
    assign w_digit     = r_bcd[4*r_idx +: 4];

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        logic [3:0] d;
        w_bcd_adj = r_bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = r_bcd[4*i +: 4];
            w_bcd_adj[4*i +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
        end
    end

    // highest nonzero digit, digit zero when the value is zero
    always_comb begin
        w_first_nz = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                w_first_nz = IDX_W'(i);
            end
        end
    end

    // sequencer with the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // output valid: set on a new character, held while stalled
            r_out_valid <= w_emit || (r_out_valid && i_stall);
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_neg   <= i_job_neg;
                        r_shift <= i_job_mag;
                        r_bcd   <= '0;
                        r_cnt   <= CNT_W'(VALUE_BITS);
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_bcd   <= {w_bcd_adj[BCD_BITS-2:0], r_shift[VALUE_BITS-1]};
                    r_shift <= r_shift << 1;
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    r_idx   <= w_first_nz;
                    r_state <= r_neg ? S_SIGN : S_DIGIT;
                end
                S_SIGN: begin
                    if (w_slot_free) begin
                        r_char      <= sitoa_pkg::MINUS_CODE;
                        r_last      <= 1'b0;
                        r_state     <= S_DIGIT;
                    end
                end
                S_DIGIT: begin
                    if (w_slot_free) begin
                        r_char      <= sitoa_pkg::DIGIT_BASE + {2'b00, w_digit};
                        r_last      <= (r_idx == '0);
                        if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;

endmodule

// ----- rtl/signed_int_to_decimal_ascii_core.sv -----
// top level: signed integer to decimal ascii character stream
//
// input channel: i_valid / o_stall carry one signed value per beat on i_value.
// output channel: o_valid / i_stall carry one character per beat on
// o_char_code, '-' first for negative values, then the digits most
// significant first with no leading zeros; o_is_last marks the final digit.
// zero gives the single character '0'; the most negative value converts fully.
// a front register takes the beat and forms sign and magnitude, a two-entry
// queue holds pending values, and the back stage converts one value at a time.
// a value passes the front register, a queue slot, the conversion, the digit
// search and the output register before its first character appears.
// the serial shift-add converter of VALUE_BITS steps limits the value rate:
// the back stage takes no new value until its last character is issued.
// up to three further values are taken while one is being converted.
// reset (synchronous, active low) empties the queue and the output register.
// a stall on the output holds the character; the converter waits behind it
// and the input stalls once the queue and the front register are full.
module signed_int_to_decimal_ascii_core #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [VALUE_BITS-1:0]    i_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [sitoa_pkg::CHAR_BITS-1:0] o_char_code,
    output logic                            o_is_last
);

    logic                  w_f_valid;
    logic                  w_f_stall;
    logic                  w_f_neg;
    logic [VALUE_BITS-1:0] w_f_mag;
    logic                  w_q_valid;
    logic                  w_q_stall;
    logic [VALUE_BITS:0]   w_q_data;

    // sign and magnitude split
    sitoa_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_job_valid (w_f_valid),
        .i_job_stall (w_f_stall),
        .o_job_neg   (w_f_neg),
        .o_job_mag   (w_f_mag)
    );

    // pending jobs
    sitoa_queue #(.WIDTH(VALUE_BITS + 1)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_stall (w_f_stall),
        .i_data  ({w_f_neg, w_f_mag}),
        .o_valid (w_q_valid),
        .i_stall (w_q_stall),
        .o_data  (w_q_data)
    );

    // conversion and character emission
    sitoa_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_q_valid),
        .o_job_stall (w_q_stall),
        .i_job_neg   (w_q_data[VALUE_BITS]),
        .i_job_mag   (w_q_data[VALUE_BITS-1:0]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last)
    );

    // only a minus sign or a decimal digit leaves the block
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == sitoa_pkg::MINUS_CODE ||
                     (o_char_code >= sitoa_pkg::DIGIT_BASE &&
                      o_char_code <= sitoa_pkg::DIGIT_BASE + 6'd9)))
        else $error("character out of range");

    // a minus sign never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_code == sitoa_pkg::MINUS_CODE) |-> !o_is_last)
        else $error("minus sign flagged as last");

    // a transferred minus sign is not directly followed by a second minus sign
    a_minus_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_char_code == sitoa_pkg::MINUS_CODE) |=>
            !(o_valid && o_char_code == sitoa_pkg::MINUS_CODE))
        else $error("two minus signs in a row");

    // nothing is shown in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid after reset");

endmodule
